// ===== design/pilp_pkg.sv =====
// Package for the prefixed integer literal parser: parse phase type, result
// codes, character codes and default limit. No dependencies.
`default_nettype none

package pilp_pkg;

   // Largest value a constant may take before it saturates.
   localparam int unsigned VALUE_LIMIT_DEFAULT = 4095;

   localparam int unsigned CH_W    = 8;
   localparam int unsigned VALUE_W = 12;
   localparam int unsigned CODE_W  = 2;

   typedef enum logic [2:0] {
      PH_IDLE = 3'd0,
      PH_ZERO = 3'd1,
      PH_DEC  = 3'd2,
      PH_HEX  = 3'd3,
      PH_BIN  = 3'd4,
      PH_OCT  = 3'd5
   } phase_type;

   typedef enum logic [CODE_W-1:0] {
      ERR_OK         = 2'd0,
      ERR_BAD_PREFIX = 2'd1,
      ERR_DIGIT      = 2'd2,
      ERR_TOO_LARGE  = 2'd3
   } error_type;

   typedef enum logic [CODE_W-1:0] {
      RADIX_DEC = 2'd0,
      RADIX_HEX = 2'd1,
      RADIX_BIN = 2'd2,
      RADIX_OCT = 2'd3
   } radix_type;

   localparam logic [CH_W-1:0] CH_TAB   = 8'd9;
   localparam logic [CH_W-1:0] CH_CR    = 8'd13;
   localparam logic [CH_W-1:0] CH_SPACE = 8'd32;
   localparam logic [CH_W-1:0] CH_0     = 8'd48;
   localparam logic [CH_W-1:0] CH_1     = 8'd49;
   localparam logic [CH_W-1:0] CH_7     = 8'd55;
   localparam logic [CH_W-1:0] CH_9     = 8'd57;
   localparam logic [CH_W-1:0] CH_UC_A  = 8'd65;
   localparam logic [CH_W-1:0] CH_UC_F  = 8'd70;
   localparam logic [CH_W-1:0] CH_UC_Z  = 8'd90;
   localparam logic [CH_W-1:0] CH_LC_A  = 8'd97;
   localparam logic [CH_W-1:0] CH_LC_F  = 8'd102;
   localparam logic [CH_W-1:0] CH_LC_Z  = 8'd122;
   localparam logic [CH_W-1:0] CH_UC_B  = 8'd66;
   localparam logic [CH_W-1:0] CH_LC_B  = 8'd98;
   localparam logic [CH_W-1:0] CH_UC_O  = 8'd79;
   localparam logic [CH_W-1:0] CH_LC_O  = 8'd111;
   localparam logic [CH_W-1:0] CH_UC_X  = 8'd88;
   localparam logic [CH_W-1:0] CH_LC_X  = 8'd120;

endpackage : pilp_pkg

`default_nettype wire

// ===== design/prefixed_integer_literal_parser.sv =====
// Top level of the prefixed integer literal parser: character stream in,
// one result beat per constant out. Depends on pilp_pkg.
`default_nettype none

// The block reads an integer constant one character per beat on the req_
// channel, the first digit flagged by token_start. A leading zero followed by
// x, b or o (either case) selects hex, binary or octal; any other letter there
// is answered at once with a bad-prefix result. All other constants are
// decimal. A whitespace character or an end_of_input beat closes the constant
// and a single result beat follows on the rsp_ channel, carrying the value
// (saturated at VALUE_LIMIT and flagged too large above it), an error code and
// the radix. Invalid digits are skipped and reported as a digit error. A new
// token_start drops an unfinished constant silently. Every beat takes one
// clock: the character is decoded and folded into the running value (a shift,
// or a shift-add for decimal, and one compare against the limit) in the same
// cycle it is accepted, and the result sits in an output register in the cycle
// after the closing beat. req_tready falls only while a result waits in that
// register and rsp_tready is low, so with a ready sink the block takes a
// character on every clock.
module prefixed_integer_literal_parser #(
   parameter int unsigned VALUE_LIMIT = pilp_pkg::VALUE_LIMIT_DEFAULT
) (
   input  wire logic         clock,
   input  wire logic         reset,
   // Character stream.
   input  wire logic         req_tvalid,
   output logic              req_tready,
   input  wire logic [7:0]   req_tdata,   // [7:0] ch
   input  wire logic [1:0]   req_tuser,   // [0] token_start, [1] end_of_input
   // Results.
   output logic              rsp_tvalid,
   input  wire logic         rsp_tready,
   output logic [15:0]       rsp_tdata    // [11:0] literal_value,
                                          // [13:12] error_code, [15:14] radix_used
);
   import pilp_pkg::*;

   // The running value never exceeds the limit; one digit step can reach
   // sixteen times the limit plus fifteen.
   localparam int unsigned ACC_W = $clog2(VALUE_LIMIT + 1);
   localparam int unsigned SUM_W = ACC_W + 5;
   localparam logic [ACC_W-1:0] LIMIT_ACC = ACC_W'(VALUE_LIMIT);
   localparam logic [SUM_W-1:0] LIMIT_SUM = SUM_W'(VALUE_LIMIT);

   // Parse state.
   phase_type         phase_ff, phase_in;
   logic [ACC_W-1:0]  acc_ff, acc_in;
   logic              too_large_ff, too_large_in;
   logic              digit_err_ff, digit_err_in;
   logic              have_digit_ff, have_digit_in;

   // Output register.
   logic                rsp_valid_ff;
   logic [VALUE_W-1:0]  value_ff, value_in;
   error_type           err_ff, err_in;
   radix_type           radix_ff, radix_in;
   logic                emit;

   // Input beat decode.
   logic              accept;
   logic [CH_W-1:0]   ch;
   logic              start;
   logic              eoi;
   logic              is_space;
   logic              is_alpha;
   logic              term;
   logic              phase_live;

   // Digit step.
   phase_type         acc_phase;
   logic [ACC_W-1:0]  acc_base;
   logic              too_large_base;
   logic              digit_ok;
   logic [3:0]        digit;
   logic [SUM_W-1:0]  acc_wide;
   logic [SUM_W-1:0]  step_sum;
   logic              step_over;
   logic [ACC_W-1:0]  step_acc;

   // Closing result.
   radix_type         close_radix;
   logic [ACC_W-1:0]  close_value;
   logic [SUM_W-1:0]  close_wide;
   error_type         close_err;

   assign req_tready = !rsp_valid_ff || rsp_tready;
   assign accept     = req_tvalid && req_tready;
   assign ch         = req_tdata;
   assign start      = req_tuser[0];
   assign eoi        = req_tuser[1];

   assign is_space = (ch == CH_SPACE) || ((ch >= CH_TAB) && (ch <= CH_CR));
   assign is_alpha = ((ch >= CH_UC_A) && (ch <= CH_UC_Z)) ||
                     ((ch >= CH_LC_A) && (ch <= CH_LC_Z));
   assign term     = eoi || is_space;

   always_comb begin
      unique case (phase_ff)
         PH_ZERO, PH_DEC, PH_HEX, PH_BIN, PH_OCT: phase_live = 1'b1;
         default:                                 phase_live = 1'b0;
      endcase
   end

   // A new constant and the character after a leading zero both step in
   // decimal from the cleared state or the current state respectively.
   assign acc_phase      = (start || (phase_ff == PH_ZERO)) ? PH_DEC : phase_ff;
   assign acc_base       = start ? '0 : acc_ff;
   assign too_large_base = start ? 1'b0 : too_large_ff;

   always_comb begin
      digit_ok = 1'b0;
      digit    = ch[3:0];
      unique case (acc_phase)
         PH_HEX: begin
            if ((ch >= CH_0) && (ch <= CH_9)) begin
               digit_ok = 1'b1;
            end else if (((ch >= CH_UC_A) && (ch <= CH_UC_F)) ||
                         ((ch >= CH_LC_A) && (ch <= CH_LC_F))) begin
               digit_ok = 1'b1;
               digit    = ch[3:0] + 4'd9;
            end
         end
         PH_BIN: digit_ok = (ch == CH_0) || (ch == CH_1);
         PH_OCT: digit_ok = (ch >= CH_0) && (ch <= CH_7);
         default: digit_ok = (ch >= CH_0) && (ch <= CH_9);
      endcase
   end

   assign acc_wide = SUM_W'(acc_base);

   always_comb begin
      unique case (acc_phase)
         PH_HEX:  step_sum = (acc_wide << 4) + SUM_W'(digit);
         PH_BIN:  step_sum = (acc_wide << 1) + SUM_W'(digit);
         PH_OCT:  step_sum = (acc_wide << 3) + SUM_W'(digit);
         default: step_sum = (acc_wide << 3) + (acc_wide << 1) + SUM_W'(digit);
      endcase
   end

   assign step_over = step_sum > LIMIT_SUM;
   assign step_acc  = step_over ? LIMIT_ACC : step_sum[ACC_W-1:0];

   // Result for a closing beat: a prefix without digits outranks a skipped
   // digit, which outranks saturation; a saturated value is always shown.
   always_comb begin
      unique case (phase_ff)
         PH_HEX:  close_radix = RADIX_HEX;
         PH_BIN:  close_radix = RADIX_BIN;
         PH_OCT:  close_radix = RADIX_OCT;
         default: close_radix = RADIX_DEC;
      endcase
      close_value = acc_ff;
      close_err   = ERR_OK;
      priority if ((close_radix != RADIX_DEC) && !have_digit_ff) begin
         close_err   = ERR_DIGIT;
         close_value = '0;
      end else if (digit_err_ff) begin
         close_err = ERR_DIGIT;
      end else if (too_large_ff) begin
         close_err = ERR_TOO_LARGE;
      end
      if (too_large_ff) begin
         close_value = LIMIT_ACC;
      end
   end

   assign close_wide = SUM_W'(close_value);

   // Next parse state and result.
   always_comb begin
      phase_in      = phase_ff;
      acc_in        = acc_ff;
      too_large_in  = too_large_ff;
      digit_err_in  = digit_err_ff;
      have_digit_in = have_digit_ff;
      emit          = 1'b0;
      value_in      = '0;
      err_in        = ERR_DIGIT;
      radix_in      = RADIX_DEC;
      if (accept) begin
         if (start) begin
            acc_in        = '0;
            too_large_in  = 1'b0;
            digit_err_in  = 1'b0;
            have_digit_in = 1'b0;
            if (term) begin
               phase_in = PH_IDLE;
               emit     = 1'b1;
            end else if (ch == CH_0) begin
               phase_in = PH_ZERO;
            end else begin
               phase_in = PH_DEC;
               if (!digit_ok) begin
                  digit_err_in = 1'b1;
               end else begin
                  have_digit_in = 1'b1;
                  acc_in        = step_acc;
                  too_large_in  = step_over;
               end
            end
         end else if (!phase_live) begin
            phase_in = PH_IDLE;
         end else if (term) begin
            emit          = 1'b1;
            value_in      = close_wide[VALUE_W-1:0];
            err_in        = close_err;
            radix_in      = close_radix;
            phase_in      = PH_IDLE;
            acc_in        = '0;
            too_large_in  = 1'b0;
            digit_err_in  = 1'b0;
            have_digit_in = 1'b0;
         end else if ((phase_ff == PH_ZERO) && is_alpha) begin
            priority if ((ch == CH_LC_X) || (ch == CH_UC_X)) begin
               phase_in = PH_HEX;
            end else if ((ch == CH_LC_B) || (ch == CH_UC_B)) begin
               phase_in = PH_BIN;
            end else if ((ch == CH_LC_O) || (ch == CH_UC_O)) begin
               phase_in = PH_OCT;
            end else begin
               emit          = 1'b1;
               err_in        = ERR_BAD_PREFIX;
               phase_in      = PH_IDLE;
               acc_in        = '0;
               too_large_in  = 1'b0;
               digit_err_in  = 1'b0;
               have_digit_in = 1'b0;
            end
         end else begin
            phase_in = acc_phase;
            if (!digit_ok) begin
               digit_err_in = 1'b1;
            end else begin
               have_digit_in = 1'b1;
               if (!too_large_base) begin
                  acc_in       = step_acc;
                  too_large_in = step_over;
               end
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff      <= PH_IDLE;
         acc_ff        <= '0;
         too_large_ff  <= 1'b0;
         digit_err_ff  <= 1'b0;
         have_digit_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         phase_ff      <= phase_in;
         acc_ff        <= acc_in;
         too_large_ff  <= too_large_in;
         digit_err_ff  <= digit_err_in;
         have_digit_ff <= have_digit_in;
         if (emit) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (emit) begin
         value_ff <= value_in;
         err_ff   <= err_in;
         radix_ff <= radix_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {radix_ff, err_ff, value_ff};

   // A constant that starts with its own terminator is reported as a missing
   // digit on the very next cycle.
   a_empty_token : assert property (@(posedge clock) disable iff (reset)
      accept && start && term |=> rsp_tvalid && (err_ff == ERR_DIGIT))
      else $error("empty constant did not give a missing-digit result");

   // A stray character outside any constant produces nothing.
   a_idle_silent : assert property (@(posedge clock) disable iff (reset)
      accept && !start && !phase_live |=> !rsp_tvalid)
      else $error("result produced for a character outside a constant");

   // Saturation pins the running value at the limit.
   a_saturated : assert property (@(posedge clock) disable iff (reset)
      too_large_ff |-> (acc_ff == LIMIT_ACC))
      else $error("too-large flag set but running value is not the limit");

   // A bad prefix always reports zero in decimal.
   a_bad_prefix : assert property (@(posedge clock) disable iff (reset)
      accept && emit && (err_in == ERR_BAD_PREFIX) |=>
         (value_ff == '0) && (radix_ff == RADIX_DEC) && !phase_live)
      else $error("bad-prefix result carries a value or radix");

endmodule : prefixed_integer_literal_parser

`default_nettype wire
